### design/e2q_pkg.sv
`default_nettype none

package e2q_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int OUT_FRAC_BITS = 15;
  localparam int OUT_BITS      = OUT_FRAC_BITS + 1;

  localparam int TURN_BITS    = 32;
  localparam int CORDIC_STEPS = 32;
  localparam int NAXIS        = 3;

  localparam int AXIS_ROLL  = 0;
  localparam int AXIS_PITCH = 1;
  localparam int AXIS_YAW   = 2;

  // cordic datapath, product operand, product and sum widths
  localparam int CW  = 34;
  localparam int OPW = 32;
  localparam int PW  = 2 * OPW;
  localparam int SW  = PW + 2;

  localparam int Q30       = 30;
  localparam int OUT_SHIFT = 2 * Q30 - OUT_FRAC_BITS;

  // gain-compensated unit vector, q2.30
  localparam logic signed [CW-1:0] CORDIC_START = CW'(33'sh026DD3B6A);

  localparam logic [TURN_BITS-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] quat_w;
    logic signed [OUT_BITS-1:0] quat_x;
    logic signed [OUT_BITS-1:0] quat_y;
    logic signed [OUT_BITS-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [OPW-1:0] sin_roll;
    logic signed [OPW-1:0] cos_roll;
    logic signed [OPW-1:0] sin_pitch;
    logic signed [OPW-1:0] cos_pitch;
    logic signed [OPW-1:0] sin_yaw;
    logic signed [OPW-1:0] cos_yaw;
  } trig_t;

endpackage

`default_nettype wire

### design/e2q_cordic.sv
`default_nettype none

module e2q_cordic (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_vld,
  input  e2q_pkg::angles_t angles,
  output logic             out_vld,
  output e2q_pkg::trig_t   trig
);
  import e2q_pkg::*;

  localparam int PAD = TURN_BITS - ANGLE_BITS;
  localparam logic signed [CW-1:0] OP_MAX = CW'((64'sd1 <<< (OPW - 1)) - 64'sd1);
  localparam logic signed [CW-1:0] OP_MIN = -CW'(64'sd1 <<< (OPW - 1));
  localparam logic signed [CW-1:0] Z_RES  = CW'(256);

  logic signed [ANGLE_BITS-1:0] ang [NAXIS];
  logic signed [CW-1:0]         xs  [NAXIS][CORDIC_STEPS+1];
  logic signed [CW-1:0]         ys  [NAXIS][CORDIC_STEPS+1];
  logic signed [CW-1:0]         zs  [NAXIS][CORDIC_STEPS+1];
  logic                         vld [CORDIC_STEPS+1];

  assign ang[AXIS_ROLL]  = angles.roll_angle;
  assign ang[AXIS_PITCH] = angles.pitch_angle;
  assign ang[AXIS_YAW]   = angles.yaw_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
    end
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end
  end

  for (genvar a = 0; a < NAXIS; a++) begin : g_axis
    logic signed [TURN_BITS-1:0] scaled;
    logic signed [TURN_BITS-1:0] half;

    // angle in turn units, then halved
    assign scaled = TURN_BITS'(ang[a]) << PAD;
    assign half   = scaled >>> 1;

    always_ff @(posedge clk) begin
      if (adv) begin
        xs[a][0] <= CORDIC_START;
        ys[a][0] <= '0;
        zs[a][0] <= CW'(half);
      end
    end

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [CW-1:0] at;

      assign dx = ys[a][s] >>> s;
      assign dy = xs[a][s] >>> s;
      assign at = CW'(ATAN_TURNS[s]);

      always_ff @(posedge clk) begin
        if (adv) begin
          if (!zs[a][s][CW-1]) begin
            xs[a][s+1] <= xs[a][s] - dx;
            ys[a][s+1] <= ys[a][s] + dy;
            zs[a][s+1] <= zs[a][s] - at;
          end else begin
            xs[a][s+1] <= xs[a][s] + dx;
            ys[a][s+1] <= ys[a][s] - dy;
            zs[a][s+1] <= zs[a][s] + at;
          end
        end
      end
    end
  end

  assign out_vld        = vld[CORDIC_STEPS];
  assign trig.sin_roll  = OPW'(ys[AXIS_ROLL][CORDIC_STEPS]);
  assign trig.cos_roll  = OPW'(xs[AXIS_ROLL][CORDIC_STEPS]);
  assign trig.sin_pitch = OPW'(ys[AXIS_PITCH][CORDIC_STEPS]);
  assign trig.cos_pitch = OPW'(xs[AXIS_PITCH][CORDIC_STEPS]);
  assign trig.sin_yaw   = OPW'(ys[AXIS_YAW][CORDIC_STEPS]);
  assign trig.cos_yaw   = OPW'(xs[AXIS_YAW][CORDIC_STEPS]);

  for (genvar a = 0; a < NAXIS; a++) begin : g_chk
    // sine and cosine fit the product operand width
    a_trig_fits: assert property (@(posedge clk) disable iff (rst)
      vld[CORDIC_STEPS] |->
        (xs[a][CORDIC_STEPS] >= OP_MIN && xs[a][CORDIC_STEPS] <= OP_MAX &&
         ys[a][CORDIC_STEPS] >= OP_MIN && ys[a][CORDIC_STEPS] <= OP_MAX))
      else $error("cordic result exceeds operand width");

    // residual angle has converged
    a_z_converged: assert property (@(posedge clk) disable iff (rst)
      vld[CORDIC_STEPS] |->
        (zs[a][CORDIC_STEPS] > -Z_RES && zs[a][CORDIC_STEPS] < Z_RES))
      else $error("cordic residual angle did not converge");
  end

endmodule

`default_nettype wire

### design/e2q_combine.sv
`default_nettype none

module e2q_combine (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  e2q_pkg::trig_t trig,
  output logic           out_vld,
  output e2q_pkg::quat_t quat
);
  import e2q_pkg::*;

  localparam logic signed [PW-1:0] PAIR_RND = PW'(1) << (Q30 - 1);
  localparam logic signed [SW-1:0] OUT_RND  = SW'(1) << (OUT_SHIFT - 1);
  localparam logic signed [SW-1:0] OUT_MAX  = (SW'(1) << OUT_FRAC_BITS) - SW'(1);
  localparam logic signed [SW-1:0] OUT_MIN  = -(SW'(1) << OUT_FRAC_BITS);
  localparam logic signed [SW-1:0] SUM_LIM  = SW'(1) << (2 * Q30 + 1);

  function automatic logic signed [OUT_BITS-1:0] round_sat(
    input logic signed [SW-1:0] v
  );
    logic signed [SW-1:0] r;
    r = (v + OUT_RND) >>> OUT_SHIFT;
    priority if (r > OUT_MAX) begin
      r = OUT_MAX;
    end else if (r < OUT_MIN) begin
      r = OUT_MIN;
    end
    return OUT_BITS'(r);
  endfunction

  logic                  v1, v2, v3, v4;
  logic signed [PW-1:0]  p_cc, p_ss, p_cs, p_sc;
  logic signed [OPW-1:0] cr1, sr1, cr2, sr2;
  logic signed [PW-1:0]  r_cc, r_ss, r_cs, r_sc;
  logic signed [OPW-1:0] cc, ss, cs, sc;
  logic signed [PW-1:0]  m_ccr, m_sss, m_ccs, m_ssc, m_csc, m_scs, m_scc, m_css;
  logic signed [SW-1:0]  s_w, s_x, s_y, s_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      v4      <= v3;
      out_vld <= v4;
    end
  end

  // yaw-pitch pair products
  always_ff @(posedge clk) begin
    if (adv) begin
      p_cc <= PW'(trig.cos_yaw) * PW'(trig.cos_pitch);
      p_ss <= PW'(trig.sin_yaw) * PW'(trig.sin_pitch);
      p_cs <= PW'(trig.cos_yaw) * PW'(trig.sin_pitch);
      p_sc <= PW'(trig.sin_yaw) * PW'(trig.cos_pitch);
      cr1  <= trig.cos_roll;
      sr1  <= trig.sin_roll;
    end
  end

  assign r_cc = (p_cc + PAIR_RND) >>> Q30;
  assign r_ss = (p_ss + PAIR_RND) >>> Q30;
  assign r_cs = (p_cs + PAIR_RND) >>> Q30;
  assign r_sc = (p_sc + PAIR_RND) >>> Q30;

  always_ff @(posedge clk) begin
    if (adv) begin
      cc  <= OPW'(r_cc);
      ss  <= OPW'(r_ss);
      cs  <= OPW'(r_cs);
      sc  <= OPW'(r_sc);
      cr2 <= cr1;
      sr2 <= sr1;
    end
  end

  // roll products
  always_ff @(posedge clk) begin
    if (adv) begin
      m_ccr <= PW'(cc) * PW'(cr2);
      m_sss <= PW'(ss) * PW'(sr2);
      m_ccs <= PW'(cc) * PW'(sr2);
      m_ssc <= PW'(ss) * PW'(cr2);
      m_csc <= PW'(cs) * PW'(cr2);
      m_scs <= PW'(sc) * PW'(sr2);
      m_scc <= PW'(sc) * PW'(cr2);
      m_css <= PW'(cs) * PW'(sr2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_w <= SW'(m_ccr) + SW'(m_sss);
      s_x <= SW'(m_ccs) - SW'(m_ssc);
      s_y <= SW'(m_csc) + SW'(m_scs);
      s_z <= SW'(m_scc) - SW'(m_css);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat.quat_w <= round_sat(s_w);
      quat.quat_x <= round_sat(s_x);
      quat.quat_y <= round_sat(s_y);
      quat.quat_z <= round_sat(s_z);
    end
  end

  // whole pipe freezes while the output word is held
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(v1) && $stable(v2) && $stable(v3) && $stable(v4) &&
              $stable(out_vld)))
    else $error("pipeline moved while stalled");

  a_sum_wx: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (s_w >= -SUM_LIM && s_w <= SUM_LIM && s_x >= -SUM_LIM && s_x <= SUM_LIM))
    else $error("w or x sum out of range");

  a_sum_yz: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (s_y >= -SUM_LIM && s_y <= SUM_LIM && s_z >= -SUM_LIM && s_z <= SUM_LIM))
    else $error("y or z sum out of range");

endmodule

`default_nettype wire

### design/euler_to_quaternion_unit.sv
// channel   direction  handshake                  word
// angles    in         angle_valid / angle_stall  roll, pitch, yaw (16-bit binary angles)
// quat      out        quat_valid / quat_stall    w, x, y, z (signed q1.15)
//
// one word per cycle sustained while the output word is not held
// the pipe is the 33-register cordic pipe plus five product, sum and rounding stages
// synchronous reset clears the valid bits only, no clearing pass
// a held output word freezes the whole pipe and raises angle_stall
`default_nettype none

module euler_to_quaternion_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             angle_valid,
  output logic             angle_stall,
  input  e2q_pkg::angles_t angles,
  output logic             quat_valid,
  input  logic             quat_stall,
  output e2q_pkg::quat_t   quat
);
  import e2q_pkg::*;

  logic  adv;
  logic  trig_vld;
  trig_t trig;

  assign adv         = !(quat_valid && quat_stall);
  assign angle_stall = !adv;

  e2q_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (angle_valid),
    .angles  (angles),
    .out_vld (trig_vld),
    .trig    (trig)
  );

  e2q_combine u_combine (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (trig_vld),
    .trig    (trig),
    .out_vld (quat_valid),
    .quat    (quat)
  );

endmodule

`default_nettype wire
